// ===== hw/rtl/twt_pkg.sv =====
// ----------------------------------------------------------------------------
// twt_pkg
// Shared types and constants of the check-in watchdog table.
// ----------------------------------------------------------------------------
package twt_pkg;

   localparam int OP_W     = 2;
   localparam int TICK_W   = 32;
   localparam int ID_W     = 32;
   localparam int MS_W     = 32;
   localparam int RATE_W   = 10;
   localparam int MS_PER_S = 1000;

   // Timeout conversion. With ms = 1000 * whole + frac the tick count is
   // whole * rate + (frac * rate) / 1000. Each division by 1000 is a multiply
   // by RECIP followed by a right shift by RECIP_SH, exact for any 32-bit
   // dividend.
   localparam int                 QMS_W       = 23;          // ms / 1000
   localparam int                 FRAC_W      = 10;          // values below 1024
   localparam int                 PART_W      = 20;          // frac * rate
   localparam int                 WHOLE_W     = TICK_W + 1;  // spare bit for saturation
   localparam int                 RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP       = 32'h1062_4DD3;
   localparam int                 RECIP_SH    = 38;
   localparam int                 CONV_STAGES = 6;

   localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
   localparam logic [OP_W-1:0] OP_CHECKIN  = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

   // One operation as it travels along the row of cells.
   typedef struct packed {
      logic              valid;
      logic [OP_W-1:0]   opcode;
      logic [TICK_W-1:0] now_tick;
      logic [ID_W-1:0]   client_id;
      logic [TICK_W-1:0] limit_ticks;
      logic              pending;   // register still looking for a free entry
      logic              found;     // check-in already restamped an entry
      logic              status;    // a timeout has been seen so far
   } token_type;

endpackage

// ===== hw/rtl/twt_cell.sv =====
// ----------------------------------------------------------------------------
// twt_cell
// One table entry; acts on the passing token and hands it to the next cell.
// ----------------------------------------------------------------------------
module twt_cell (
   input  logic               clock,
   input  logic               reset,
   input  twt_pkg::token_type tok_in,
   output twt_pkg::token_type tok_out
);

   logic                       enabled_ff, enabled_in;
   logic [twt_pkg::ID_W-1:0]   client_ff, client_in;
   logic [twt_pkg::TICK_W-1:0] last_ff, last_in;
   logic [twt_pkg::TICK_W-1:0] limit_ff, limit_in;
   twt_pkg::token_type         tok_ff, tok_in_next;

   logic                       hit_write, hit_checkin, late;
   logic [twt_pkg::TICK_W-1:0] elapsed;

   always_comb begin
      elapsed     = tok_in.now_tick - last_ff;
      hit_write   = tok_in.valid && (tok_in.opcode == twt_pkg::OP_REGISTER)
                    && tok_in.pending && !enabled_ff;
      hit_checkin = tok_in.valid && (tok_in.opcode == twt_pkg::OP_CHECKIN)
                    && !tok_in.found && enabled_ff && (client_ff == tok_in.client_id);
      late        = tok_in.valid && (tok_in.opcode == twt_pkg::OP_CHECK)
                    && enabled_ff && (elapsed > limit_ff);

      enabled_in = enabled_ff | hit_write;
      client_in  = hit_write ? tok_in.client_id : client_ff;
      last_in    = (hit_write || hit_checkin) ? tok_in.now_tick : last_ff;
      limit_in   = hit_write ? tok_in.limit_ticks : limit_ff;

      tok_in_next         = tok_in;
      tok_in_next.pending = tok_in.pending & ~hit_write;
      tok_in_next.found   = tok_in.found | hit_checkin;
      tok_in_next.status  = tok_in.status | late;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff   <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         enabled_ff   <= enabled_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      client_ff          <= client_in;
      last_ff            <= last_in;
      limit_ff           <= limit_in;
      tok_ff.opcode      <= tok_in_next.opcode;
      tok_ff.now_tick    <= tok_in_next.now_tick;
      tok_ff.client_id   <= tok_in_next.client_id;
      tok_ff.limit_ticks <= tok_in_next.limit_ticks;
      tok_ff.pending     <= tok_in_next.pending;
      tok_ff.found       <= tok_in_next.found;
      tok_ff.status      <= tok_in_next.status;
   end

   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/twt_conv.sv =====
// ----------------------------------------------------------------------------
// twt_conv
// Millisecond to tick conversion: a short pipeline of reciprocal
// multiplications by 1/1000 with saturation to 32 bits.
// ----------------------------------------------------------------------------
module twt_conv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [twt_pkg::MS_W-1:0]   ms,
   input  logic [twt_pkg::RATE_W-1:0] rate,
   output logic                       done,
   output logic [twt_pkg::TICK_W-1:0] ticks
);

   logic [twt_pkg::CONV_STAGES-1:0] stage_ff, stage_in;
   logic [twt_pkg::MS_W-1:0]        ms_ff, ms_in;
   logic [twt_pkg::RATE_W-1:0]      rate_ff, rate_in;
   logic [twt_pkg::QMS_W-1:0]       quo_ff, quo_in;
   logic [twt_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic [twt_pkg::WHOLE_W-1:0]     whole_ff, whole_in;
   logic [twt_pkg::PART_W-1:0]      part_ff, part_in;
   logic [twt_pkg::FRAC_W-1:0]      part_quo_ff, part_quo_in;
   logic [twt_pkg::TICK_W-1:0]      ticks_ff, ticks_in;

   logic [2*twt_pkg::MS_W-1:0]                   ms_prod;
   logic [twt_pkg::PART_W+twt_pkg::RECIP_W-1:0]  part_prod;
   logic [twt_pkg::WHOLE_W-1:0]                  sum;

   // The operands are held from start on, so every stage settles in turn and
   // the tick count stays put until the next start.
   always_comb begin
      stage_in    = {stage_ff[twt_pkg::CONV_STAGES-2:0], start};
      ms_in       = start ? ms : ms_ff;
      rate_in     = start ? rate : rate_ff;

      ms_prod     = (2*twt_pkg::MS_W)'(ms_ff) * (2*twt_pkg::MS_W)'(twt_pkg::RECIP);
      quo_in      = ms_prod[twt_pkg::RECIP_SH +: twt_pkg::QMS_W];

      frac_in     = twt_pkg::FRAC_W'(ms_ff - twt_pkg::MS_W'(quo_ff)
                                     * twt_pkg::MS_W'(twt_pkg::MS_PER_S));

      whole_in    = twt_pkg::WHOLE_W'(quo_ff) * twt_pkg::WHOLE_W'(rate_ff);
      part_in     = twt_pkg::PART_W'(frac_ff) * twt_pkg::PART_W'(rate_ff);

      part_prod   = (twt_pkg::PART_W+twt_pkg::RECIP_W)'(part_ff)
                    * (twt_pkg::PART_W+twt_pkg::RECIP_W)'(twt_pkg::RECIP);
      part_quo_in = part_prod[twt_pkg::RECIP_SH +: twt_pkg::FRAC_W];

      sum         = whole_ff + twt_pkg::WHOLE_W'(part_quo_ff);
      ticks_in    = sum[twt_pkg::TICK_W] ? '1 : sum[twt_pkg::TICK_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
      ms_ff       <= ms_in;
      rate_ff     <= rate_in;
      quo_ff      <= quo_in;
      frac_ff     <= frac_in;
      whole_ff    <= whole_in;
      part_ff     <= part_in;
      part_quo_ff <= part_quo_in;
      ticks_ff    <= ticks_in;
   end

   assign done  = stage_ff[twt_pkg::CONV_STAGES-1];
   assign ticks = ticks_ff;

endmodule

// ===== hw/rtl/task_checkin_watchdog_table.sv =====
// ----------------------------------------------------------------------------
// task_checkin_watchdog_table
// Check-in, check and unused opcodes pass from the request registers through
//   the row of cells to the result register; a register first turns its
//   millisecond timeout into ticks in the converter.
// Flow: one item at a time; the next request is taken only once the last
//   result has moved into the output register, which can hold it back.
// Reset clears all entry valid flags, the control state and sets the tick
//   rate to 1000; entry payloads are left as they are until written.
// ----------------------------------------------------------------------------
module task_checkin_watchdog_table #(
   parameter int MAX_CLIENTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   // Input items.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,   // opcode[1:0], now_tick[33:2],
                                     // client_id[65:34], silence_ms[97:66]
   // Results.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // status[0]
   // Tick rate register.
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [9:0]   csr_data     // tick_rate_hz[9:0]
);

   // Controller states: waiting for an item, converting a timeout, walking
   // the cells, and holding a result while the output register is occupied.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [twt_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [twt_pkg::OP_W-1:0]     op_ff, op_in;
   logic [twt_pkg::TICK_W-1:0]   now_ff, now_in;
   logic [twt_pkg::ID_W-1:0]     id_ff, id_in;
   logic                         launch_ff, launch_in;
   logic                         hold_ff, hold_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_status_ff, rsp_status_in;

   logic                         req_xfer, rsp_free, conv_start, conv_done, result;
   logic [twt_pkg::TICK_W-1:0]   conv_ticks;
   twt_pkg::token_type           chain [0:MAX_CLIENTS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // The register is only written while the block is idle, so an entry
   // stamped during a conversion always sees one stable rate.
   assign rate_in = (csr_valid && csr_ready) ? csr_data : rate_ff;

   // A register opcode first turns its millisecond timeout into ticks.
   assign conv_start = req_xfer && (req_tdata[1:0] == twt_pkg::OP_REGISTER);

   twt_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .ms    (req_tdata[97:66]),
      .rate  (rate_ff),
      .done  (conv_done),
      .ticks (conv_ticks)
   );

   // The token that enters the first cell is present for one cycle only.
   always_comb begin
      chain[0].valid       = launch_ff;
      chain[0].opcode      = op_ff;
      chain[0].now_tick    = now_ff;
      chain[0].client_id   = id_ff;
      chain[0].limit_ticks = conv_ticks;
      chain[0].pending     = (op_ff == twt_pkg::OP_REGISTER);
      chain[0].found       = 1'b0;
      chain[0].status      = 1'b0;
   end

   // Each cell holds one entry. Entries fill from the first cell on, so the
   // first disabled cell a register token meets is the next free slot.
   for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
      twt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[g]),
         .tok_out (chain[g+1])
      );
   end

   // A register token that leaves the row still pending found the table full.
   assign result = chain[MAX_CLIENTS].status
                   | ((chain[MAX_CLIENTS].opcode == twt_pkg::OP_REGISTER)
                      && chain[MAX_CLIENTS].pending);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      now_in        = now_ff;
      id_in         = id_ff;
      launch_in     = 1'b0;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               op_in  = req_tdata[1:0];
               now_in = req_tdata[33:2];
               id_in  = req_tdata[65:34];
               if (conv_start) begin
                  state_in = ST_CONV;
               end else begin
                  launch_in = 1'b1;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               launch_in = 1'b1;
               state_in  = ST_RUN;
            end
         end
         ST_RUN: begin
            if (chain[MAX_CLIENTS].valid) begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = result;
                  state_in      = ST_IDLE;
               end else begin
                  hold_in  = result;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = hold_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rate_ff      <= twt_pkg::RATE_W'(twt_pkg::MS_PER_S);
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rate_ff      <= rate_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      now_ff        <= now_in;
      id_ff         <= id_in;
      hold_ff       <= hold_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff};

endmodule

// ===== tb/watchdog_status_check.sv =====
// ----------------------------------------------------------------------------
// watchdog_status_check
// Watches the request, result and tick rate channels of the check-in
// watchdog table. It keeps its own copy of the client table, works out the
// status that each accepted request must produce, and compares every result
// transfer in order against those expected statuses.
// ----------------------------------------------------------------------------
module watchdog_status_check #(
   parameter int MAX_CLIENTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,   // opcode[1:0], now_tick[33:2],
                                     // client_id[65:34], silence_ms[97:66]
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,   // status[0]
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [9:0]   csr_data,    // tick_rate_hz[9:0]
   output int           fail_count,
   output int           outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   // Beyond this many reports the failures are only counted.
   localparam int REPORT_CAP = 200;

   logic [twt_pkg::ID_W-1:0]   client_of   [MAX_CLIENTS];
   logic [twt_pkg::TICK_W-1:0] seen_at     [MAX_CLIENTS];
   logic [twt_pkg::TICK_W-1:0] limit_ticks [MAX_CLIENTS];
   logic                       watched     [MAX_CLIENTS];
   int                         clients_held;
   logic [twt_pkg::RATE_W-1:0] rate_hz;
   logic                       status_due[$];
   logic                       want_status;
   int                         error_total;
   int                         k;

   // Milliseconds to ticks at the current rate: full-width product, truncated
   // quotient, saturated to the tick width.
   function automatic logic [twt_pkg::TICK_W-1:0] ms_to_limit(
      input logic [twt_pkg::MS_W-1:0] ms);
      logic [63:0] ticks;
      ticks = 64'(ms);
      ticks = ticks * 64'(rate_hz);
      ticks = ticks / 64'(twt_pkg::MS_PER_S);
      if (ticks > 64'hFFFF_FFFF) begin
         ticks = 64'hFFFF_FFFF;
      end
      return ticks[twt_pkg::TICK_W-1:0];
   endfunction

   // Applies one request to the table copy and returns the status it earns.
   function automatic logic status_after(input logic [103:0] word);
      logic [twt_pkg::OP_W-1:0]   op;
      logic [twt_pkg::TICK_W-1:0] now;
      logic [twt_pkg::ID_W-1:0]   id;
      logic [twt_pkg::MS_W-1:0]   ms;
      logic [twt_pkg::TICK_W-1:0] elapsed;
      logic                       status;
      logic                       hit;
      int                         i;
      op     = word[1:0];
      now    = word[33:2];
      id     = word[65:34];
      ms     = word[97:66];
      status = 1'b0;
      hit    = 1'b0;
      case (op)
         twt_pkg::OP_REGISTER: begin
            if (clients_held >= MAX_CLIENTS) begin
               status = 1'b1;
            end else begin
               client_of[clients_held]   = id;
               seen_at[clients_held]     = now;
               limit_ticks[clients_held] = ms_to_limit(ms);
               watched[clients_held]     = 1'b1;
               clients_held++;
            end
         end
         twt_pkg::OP_CHECKIN: begin
            // Only the lowest-numbered entry with this identifier is restamped.
            for (i = 0; i < clients_held; i++) begin
               if (!hit && client_of[i] == id) begin
                  seen_at[i] = now;
                  hit        = 1'b1;
               end
            end
         end
         twt_pkg::OP_CHECK: begin
            for (i = 0; i < clients_held; i++) begin
               if (watched[i]) begin
                  elapsed = now - seen_at[i];
                  if (elapsed > limit_ticks[i]) begin
                     status = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return status;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (k = 0; k < MAX_CLIENTS; k++) begin
            watched[k] = 1'b0;
         end
         clients_held = 0;
         rate_hz      = 10'd1000;
         error_total  = 0;
         status_due.delete();
         fail_count  <= 0;
         outstanding <= 0;
      end else begin
         // Results are matched before new requests are queued, so a request
         // accepted on this edge can never pair with a result on the same edge.
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               if (error_total < REPORT_CAP) begin
                  $error("status: none expected, actual %0d", rsp_tdata[0]);
               end
               error_total++;
            end else begin
               want_status = status_due.pop_front();
               if (rsp_tdata[0] !== want_status) begin
                  if (error_total < REPORT_CAP) begin
                     $error("status: expected %0d, actual %0d", want_status, rsp_tdata[0]);
                  end
                  error_total++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            rate_hz = csr_data;
         end
         if (req_tvalid && req_tready) begin
            status_due.push_back(status_after(req_tdata));
         end
         outstanding <= status_due.size();
         fail_count  <= error_total;
      end
   end

endmodule

// ===== tb/task_checkin_watchdog_table_test.sv =====
// ----------------------------------------------------------------------------
// task_checkin_watchdog_table_test
// Drives the check-in watchdog table with a short directed walk through its
// corner cases and then with rounds of check-ins and checks at a moving tick,
// mixed with noise, under random idling on both channels. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module task_checkin_watchdog_table_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                       MAX_CLIENTS  = 8;
   localparam logic [twt_pkg::OP_W-1:0] OP_UNUSED    = 2'd3;
   localparam int                       RANDOM_ITEMS = 1530;
   localparam int                       CFG_SPACING  = 350;
   localparam int                       LONG_STALL   = 700;
   localparam int                       STALL_AT     = 200;
   localparam int                       DRAIN_CYCLES = 64;
   localparam int                       CYCLE_LIMIT  = 1000000;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;   // opcode[1:0], now_tick[33:2],
                                    // client_id[65:34], silence_ms[97:66]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;         // status[0]
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [9:0]   csr_data   = '0;   // tick_rate_hz[9:0]

   int fail_count;
   int outstanding;
   int cycle_count = 0;

   // Sender bookkeeping: transfers offered so far, whether the current stretch
   // runs without gaps, and the identifiers that got a table entry.
   int                         sent_count  = 0;
   logic                       send_burst  = 1'b0;
   int                         registered  = 0;
   logic [twt_pkg::ID_W-1:0]   known_ids[$];
   logic [twt_pkg::TICK_W-1:0] cur_tick;
   logic [twt_pkg::ID_W-1:0]   dup_id;

   task_checkin_watchdog_table #(
      .MAX_CLIENTS(MAX_CLIENTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   watchdog_status_check #(
      .MAX_CLIENTS(MAX_CLIENTS)
   ) i_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs on a handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("task_checkin_watchdog_table: mismatch");
         $finish;
      end
   end

   // Offers one request and returns at the edge where its transfer happens.
   // Every 40 transfers the sender decides whether the next stretch is a burst
   // with no gaps or has random gaps. With no gap, valid simply stays high
   // and only the data changes, so valid never gets two updates in one step.
   task automatic send_item(input logic [twt_pkg::OP_W-1:0] op,
                            input logic [twt_pkg::TICK_W-1:0] now,
                            input logic [twt_pkg::ID_W-1:0] id,
                            input logic [twt_pkg::MS_W-1:0] ms);
      int gap;
      if (sent_count % 40 == 0) begin
         send_burst = ($urandom_range(0, 3) == 0);
      end
      gap = send_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'b0, ms, id, now, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Registration also records which identifiers really got an entry, so the
   // random rounds can keep those clients alive.
   task automatic register_client(input logic [twt_pkg::ID_W-1:0] id,
                                  input logic [twt_pkg::TICK_W-1:0] now,
                                  input logic [twt_pkg::MS_W-1:0] ms);
      send_item(twt_pkg::OP_REGISTER, now, id, ms);
      if (registered < MAX_CLIENTS) begin
         known_ids.push_back(id);
      end
      registered++;
   endtask

   // Stops offering and waits until every expected result has come back. The
   // first edge lets the checker count a transfer that happened on this edge.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Tick rate writes happen only while the block has nothing in flight.
   task automatic write_rate(input logic [twt_pkg::RATE_W-1:0] rate);
      wait_idle();
      csr_data  <= rate;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Result side. It draws a stall before each result, with burst stretches
   // like the sender, and once holds off for a long stretch so the block
   // backs up and stops taking requests while the sender keeps offering.
   initial begin
      int   rx_count;
      int   gap;
      logic rx_burst;
      rx_count = 0;
      rx_burst = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rx_count % 40 == 0) begin
            rx_burst = ($urandom_range(0, 3) == 0);
         end
         if (rx_count == STALL_AT) begin
            gap = LONG_STALL;
         end else begin
            gap = rx_burst ? 0 : $urandom_range(0, 18);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rx_count++;
      end
   end

   // Stimulus and verdict.
   initial begin
      int   next_cfg;
      int   pick;
      logic all_alive;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset tick rate of 1000. A zero timeout times
      // out as soon as one tick passes, but not when elapsed equals the limit.
      dup_id = 32'h5A5A_0001;
      register_client(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_item(twt_pkg::OP_CHECK, 32'h0000_0000, '0, '0);
      send_item(twt_pkg::OP_CHECK, 32'h0000_0001, '0, '0);
      send_item(twt_pkg::OP_CHECKIN, 32'hFFFF_FFF0, 32'h0000_0000, '0);
      // An identifier nobody registered changes nothing.
      send_item(twt_pkg::OP_CHECKIN, 32'h0000_0007, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(twt_pkg::OP_CHECK, 32'hFFFF_FFF0, '0, '0);
      // The unused opcode is ignored even with every field bit set.
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Two entries with the same identifier. The second has a limit one
      // short of the full range, so it times out only when elapsed wraps to
      // all ones; the check just before the restamp tick exposes a check-in
      // that wrongly restamps it too. Time wraps past zero on the way.
      register_client(dup_id, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      register_client(dup_id, 32'hFFFF_FFF0, 32'hFFFF_FFFE);
      send_item(twt_pkg::OP_CHECKIN, 32'h0000_0010, dup_id, '0);
      send_item(twt_pkg::OP_CHECKIN, 32'h0000_000F, 32'h0000_0000, '0);
      send_item(twt_pkg::OP_CHECK, 32'h0000_000F, '0, '0);

      // Highest rate: the largest timeout saturates, and 50 ms truncates to
      // 51 ticks, probed at exactly the limit and one tick beyond.
      write_rate(10'd1023);
      register_client(32'hFFFF_FFFF, 32'h0000_0020, 32'hFFFF_FFFF);
      register_client(32'h8000_0001, 32'h0000_0020, 32'd50);
      send_item(twt_pkg::OP_CHECKIN, 32'h0000_0053, 32'h0000_0000, '0);
      send_item(twt_pkg::OP_CHECK, 32'h0000_0053, '0, '0);
      send_item(twt_pkg::OP_CHECKIN, 32'h0000_0054, 32'h0000_0000, '0);
      send_item(twt_pkg::OP_CHECK, 32'h0000_0054, '0, '0);

      // A zero rate turns any timeout into zero ticks.
      write_rate(10'd0);
      register_client(32'hAAAA_5555, 32'h0000_0060, 32'hFFFF_FFFF);
      write_rate(10'd1);
      register_client(32'h5555_AAAA, 32'h0000_0060, 32'd2999);

      // The table fills up; the registrations after that must report full.
      write_rate(10'd512);
      register_client($urandom, 32'h0000_0060, $urandom_range(1000, 2000000));
      register_client($urandom, 32'h0000_0060, $urandom_range(1000, 2000000));
      register_client($urandom, 32'h0000_0060, $urandom);
      register_client($urandom, 32'h0000_0070, $urandom);

      // Random part. Most of it is rounds in which time moves on, the known
      // clients check in (all of them, or a random share), and a check
      // follows a few ticks later. Now and then time jumps anywhere, which
      // also exercises wrapping elapsed times. The rest is noise: any opcode
      // with random fields, registrations into the full table and check-ins
      // for identifiers that are not there. The tick rate is rewritten from
      // time to time between phases.
      cur_tick = 32'h0000_0100;
      next_cfg = sent_count + CFG_SPACING;
      while (sent_count < RANDOM_ITEMS) begin
         if (sent_count >= next_cfg) begin
            write_rate(twt_pkg::RATE_W'($urandom_range(0, 1023)));
            next_cfg = sent_count + CFG_SPACING;
         end
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            send_item(twt_pkg::OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
         end else if (pick == 1) begin
            register_client($urandom, cur_tick, $urandom);
         end else if (pick == 2) begin
            send_item(twt_pkg::OP_CHECKIN, cur_tick, $urandom, $urandom);
         end else begin
            if ($urandom_range(0, 15) == 0) begin
               cur_tick = $urandom;
            end else begin
               cur_tick = cur_tick + $urandom_range(0, 40);
            end
            all_alive = 1'($urandom_range(0, 1));
            foreach (known_ids[n]) begin
               if (all_alive || $urandom_range(0, 3) != 0) begin
                  send_item(twt_pkg::OP_CHECKIN, cur_tick, known_ids[n], $urandom);
               end
            end
            send_item(twt_pkg::OP_CHECK, cur_tick + $urandom_range(0, 3), $urandom, $urandom);
         end
      end

      // Last phase back at the reset rate, then drain.
      write_rate(10'd1000);
      send_item(twt_pkg::OP_CHECK, cur_tick, '0, '0);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("task_checkin_watchdog_table: match");
      end else begin
         $display("task_checkin_watchdog_table: mismatch");
      end
      $finish;
   end

endmodule
